// File: rtl/yuyv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV converter package
// Shared types, register indexes and reset gains for the YUYV to BGR888 core.
// ----------------------------------------------------------------------------
package yuyv_pkg;

  // Coefficient registers are 12-bit unsigned fixed-point gains.
  localparam int unsigned CoefWidth = 12;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned PixWidth = 8;

  typedef logic [CoefWidth-1:0]   coef_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
  typedef logic [PixWidth-1:0]    pix_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CfgRedFromV   = 2'd0;
  localparam cfg_idx_t CfgGreenFromU = 2'd1;
  localparam cfg_idx_t CfgGreenFromV = 2'd2;
  localparam cfg_idx_t CfgBlueFromU  = 2'd3;

  // Reset gains in Q10 (BT.601: 1.402, 0.344, 0.714, 1.772).
  localparam coef_t RstRedFromV   = 12'd1436;
  localparam coef_t RstGreenFromU = 12'd352;
  localparam coef_t RstGreenFromV = 12'd731;
  localparam coef_t RstBlueFromU  = 12'd1815;

  // The set of gains that the datapath uses.
  typedef struct packed {
    coef_t red_from_v;
    coef_t green_from_u;
    coef_t green_from_v;
    coef_t blue_from_u;
  } coef_set_t;

  // Two output pixels in blue, green, red order.
  typedef struct packed {
    pix_t blue_first;
    pix_t green_first;
    pix_t red_first;
    pix_t blue_second;
    pix_t green_second;
    pix_t red_second;
  } bgr_pair_t;

endpackage
`default_nettype wire

// File: rtl/yuyv_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV converter coefficient registers
// Holds the four chroma gains, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module yuyv_cfg_regs
  import yuyv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire cfg_idx_t  cfg_index_i,
  input  wire coef_t     cfg_wdata_i,
  output coef_set_t      coefs_o
);

  coef_set_t coefs_q, coefs_d;

  // Decode the write index onto the matching gain.
  always_comb begin
    coefs_d = coefs_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRedFromV:   coefs_d.red_from_v   = cfg_wdata_i;
        CfgGreenFromU: coefs_d.green_from_u = cfg_wdata_i;
        CfgGreenFromV: coefs_d.green_from_v = cfg_wdata_i;
        CfgBlueFromU:  coefs_d.blue_from_u  = cfg_wdata_i;
        default:       coefs_d = coefs_q;
      endcase
    end
  end

  // Gains reset to the BT.601 values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.red_from_v   <= RstRedFromV;
      coefs_q.green_from_u <= RstGreenFromU;
      coefs_q.green_from_v <= RstGreenFromV;
      coefs_q.blue_from_u  <= RstBlueFromU;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  assign coefs_o = coefs_q;

endmodule
`default_nettype wire

// File: rtl/yuyv_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV converter color math
// Computes both BGR pixels of one macropixel: luma plus signed chroma terms,
// floor shift by the fraction bits and clamp to 0..255.
// ----------------------------------------------------------------------------
module yuyv_calc
  import yuyv_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 10
) (
  input  wire coef_set_t coefs_i,
  input  wire pix_t      luma_first_i,
  input  wire pix_t      chroma_blue_i,
  input  wire pix_t      luma_second_i,
  input  wire pix_t      chroma_red_i,
  output bgr_pair_t      pair_o
);

  // A product of a 13-bit signed gain and a 9-bit signed chroma fits 22 bits.
  localparam int unsigned ProdWidth = CoefWidth + 1 + PixWidth + 1;
  localparam int unsigned BaseWidth = PixWidth + COEF_FRAC_BITS;
  localparam int unsigned SumWidth =
      ((BaseWidth > ProdWidth) ? BaseWidth : ProdWidth) + 2;

  typedef logic signed [SumWidth-1:0] sum_t;

  logic signed [PixWidth:0]    du, dv;
  logic signed [ProdWidth-1:0] p_blue_u, p_green_u, p_green_v, p_red_v;
  sum_t base_first, base_second;
  sum_t ext_blue_u, ext_green_u, ext_green_v, ext_red_v;

  // Floor shift and saturate one channel sum to a byte.
  function automatic pix_t clamp_sum(input sum_t sum);
    pix_t res;
    if (sum[SumWidth-1]) begin
      res = '0;
    end else if (|sum[SumWidth-2:COEF_FRAC_BITS+PixWidth]) begin
      res = '1;
    end else begin
      res = sum[COEF_FRAC_BITS+PixWidth-1:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  // Remove the chroma offset of 128.
  assign du = $signed({1'b0, chroma_blue_i}) - 9'sd128;
  assign dv = $signed({1'b0, chroma_red_i}) - 9'sd128;

  // Four chroma products, shared by both pixels.
  assign p_blue_u  = ProdWidth'($signed({1'b0, coefs_i.blue_from_u}))  * ProdWidth'(du);
  assign p_green_u = ProdWidth'($signed({1'b0, coefs_i.green_from_u})) * ProdWidth'(du);
  assign p_green_v = ProdWidth'($signed({1'b0, coefs_i.green_from_v})) * ProdWidth'(dv);
  assign p_red_v   = ProdWidth'($signed({1'b0, coefs_i.red_from_v}))   * ProdWidth'(dv);

  assign ext_blue_u  = sum_t'(p_blue_u);
  assign ext_green_u = sum_t'(p_green_u);
  assign ext_green_v = sum_t'(p_green_v);
  assign ext_red_v   = sum_t'(p_red_v);

  // Luma scaled to the fixed-point grid.
  assign base_first  = $signed({{(SumWidth-BaseWidth){1'b0}}, luma_first_i,
                                {COEF_FRAC_BITS{1'b0}}});
  assign base_second = $signed({{(SumWidth-BaseWidth){1'b0}}, luma_second_i,
                                {COEF_FRAC_BITS{1'b0}}});

  // Channel sums and clamps for both pixels.
  assign pair_o.blue_first   = clamp_sum(base_first + ext_blue_u);
  assign pair_o.green_first  = clamp_sum(base_first - ext_green_u - ext_green_v);
  assign pair_o.red_first    = clamp_sum(base_first + ext_red_v);
  assign pair_o.blue_second  = clamp_sum(base_second + ext_blue_u);
  assign pair_o.green_second = clamp_sum(base_second - ext_green_u - ext_green_v);
  assign pair_o.red_second   = clamp_sum(base_second + ext_red_v);

endmodule
`default_nettype wire

// File: rtl/yuyv_to_bgr888_converter_core.sv
`default_nettype none
// Data path: after the input accept edge the word sits in the input register,
// then the color math loads the result register, which raises out_valid_o.
// Throughput: one macropixel per cycle; the input stalls only when both
// registers hold words and the output word is not taken.
// Reset: asynchronous active low; clears both valid flags and restores the
// BT.601 gains.
// ----------------------------------------------------------------------------
// YUYV to BGR888 converter core
// Converts one YUYV 4:2:2 macropixel into two BGR888 pixels per word.
// ----------------------------------------------------------------------------
module yuyv_to_bgr888_converter_core
  import yuyv_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 10
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // Configuration write port.
  input  wire logic      cfg_we_i,
  input  wire cfg_idx_t  cfg_index_i,
  input  wire coef_t     cfg_wdata_i,
  // Input macropixel channel.
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pix_t      luma_first_i,
  input  wire pix_t      chroma_blue_i,
  input  wire pix_t      luma_second_i,
  input  wire pix_t      chroma_red_i,
  // Output pixel pair channel.
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pix_t           blue_first_o,
  output pix_t           green_first_o,
  output pix_t           red_first_o,
  output pix_t           blue_second_o,
  output pix_t           green_second_o,
  output pix_t           red_second_o
);

  coef_set_t coefs;
  bgr_pair_t pair_d, pair_q;
  logic      in_vld_q, out_vld_q;
  logic      out_adv, in_adv;
  pix_t      luma_first_q, chroma_blue_q, luma_second_q, chroma_red_q;

  // Coefficient storage.
  yuyv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coefs_o     (coefs)
  );

  // Stage handshakes: the result register loads when empty or drained.
  assign out_adv    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_adv;
  assign in_adv     = in_valid_i && in_ready_o;

  // Input register valid and result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      luma_first_q  <= luma_first_i;
      chroma_blue_q <= chroma_blue_i;
      luma_second_q <= luma_second_i;
      chroma_red_q  <= chroma_red_i;
    end
  end

  // Color math between the two registers.
  yuyv_calc #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_calc (
    .coefs_i       (coefs),
    .luma_first_i  (luma_first_q),
    .chroma_blue_i (chroma_blue_q),
    .luma_second_i (luma_second_q),
    .chroma_red_i  (chroma_red_q),
    .pair_o        (pair_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      pair_q <= pair_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign blue_first_o   = pair_q.blue_first;
  assign green_first_o  = pair_q.green_first;
  assign red_first_o    = pair_q.red_first;
  assign blue_second_o  = pair_q.blue_second;
  assign green_second_o = pair_q.green_second;
  assign red_second_o   = pair_q.red_second;

endmodule
`default_nettype wire

// File: bench/tb_yuyv_to_bgr888_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to BGR888 converter core testbench
// Sends YUYV macropixel words into the core and predicts each BGR pixel pair
// with fixed-point color math kept here. Every result word is compared
// channel by channel against the oldest prediction. Gains are rewritten
// between phases, and both handshakes idle at random rates.
// ----------------------------------------------------------------------------
module tb_yuyv_to_bgr888_converter_core
  import yuyv_pkg::*;
();

  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned CORE_LATENCY = 2;
  localparam int unsigned MAX_REPORTS = 10;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    cfg_we_i;
  cfg_idx_t cfg_index_i;
  coef_t   cfg_wdata_i;
  logic    in_valid_i;
  logic    in_ready_o;
  pix_t    luma_first_i;
  pix_t    chroma_blue_i;
  pix_t    luma_second_i;
  pix_t    chroma_red_i;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  pix_t    blue_first_o;
  pix_t    green_first_o;
  pix_t    red_first_o;
  pix_t    blue_second_o;
  pix_t    green_second_o;
  pix_t    red_second_o;

  // Gains as the core should hold them, and the pixel pairs still owed.
  coef_set_t gains;
  bgr_pair_t pending_pairs[$];

  int error_count = 0;
  int mismatch_count = 0;

  // Idling rates in percent, and a long output hold-off in cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold_cycles = 0;

  yuyv_to_bgr888_converter_core #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .blue_first_o  (blue_first_o),
    .green_first_o (green_first_o),
    .red_first_o   (red_first_o),
    .blue_second_o (blue_second_o),
    .green_second_o(green_second_o),
    .red_second_o  (red_second_o)
  );

  always #10 clk_i = ~clk_i;

  // Floor the scaled sum to a byte; negative sums give zero.
  function automatic pix_t saturate_channel(input longint sum);
    longint q;
    if (sum < 0) begin
      return '0;
    end
    q = sum >>> FRAC_BITS;
    return (q > 255) ? pix_t'(255) : pix_t'(q);
  endfunction

  // One output pixel from its luma and the shared chroma offsets.
  function automatic void color_pixel(input pix_t luma, input longint du, input longint dv,
                                      output pix_t blue, output pix_t green,
                                      output pix_t red);
    longint base;
    base = longint'(luma) <<< FRAC_BITS;
    blue  = saturate_channel(base + longint'(gains.blue_from_u) * du);
    green = saturate_channel(base - longint'(gains.green_from_u) * du
                                  - longint'(gains.green_from_v) * dv);
    red   = saturate_channel(base + longint'(gains.red_from_v) * dv);
  endfunction

  // The pixel pair that one macropixel turns into under the current gains.
  function automatic bgr_pair_t convert_macropixel(input pix_t y0, input pix_t u,
                                                   input pix_t y1, input pix_t v);
    bgr_pair_t pair;
    longint du;
    longint dv;
    du = longint'(u) - 128;
    dv = longint'(v) - 128;
    color_pixel(y0, du, dv, pair.blue_first, pair.green_first, pair.red_first);
    color_pixel(y1, du, dv, pair.blue_second, pair.green_second, pair.red_second);
    return pair;
  endfunction

  // Biased sample: extremes and the chroma midpoint show up often.
  function automatic pix_t random_sample();
    case ($urandom_range(7))
      0: return pix_t'(0);
      1: return pix_t'(255);
      2: return pix_t'(128);
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic coef_t random_gain();
    case ($urandom_range(5))
      0: return coef_t'(0);
      1: return coef_t'(4095);
      default: return coef_t'($urandom_range(4095));
    endcase
  endfunction

  // Offer one word, idling first for as many cycles as chance decides, and
  // record its prediction once it is taken.
  task automatic send_word(input pix_t y0, input pix_t u, input pix_t y1, input pix_t v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    chroma_blue_i <= u;
    luma_second_i <= y1;
    chroma_red_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pairs.push_back(convert_macropixel(y0, u, y1, v));
  endtask

  task automatic send_random_words(input int unsigned count);
    repeat (count) begin
      send_word(random_sample(), random_sample(), random_sample(), random_sample());
    end
  endtask

  // Stop offering, wait for every owed word, then let the pipeline settle.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (CORE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_gain(input cfg_idx_t index, input coef_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      CfgRedFromV:   gains.red_from_v   = value;
      CfgGreenFromU: gains.green_from_u = value;
      CfgGreenFromV: gains.green_from_v = value;
      CfgBlueFromU:  gains.blue_from_u  = value;
      default: ;
    endcase
  endtask

  task automatic apply_gains(input coef_set_t next);
    drain_results();
    write_gain(CfgRedFromV, next.red_from_v);
    write_gain(CfgGreenFromU, next.green_from_u);
    write_gain(CfgGreenFromV, next.green_from_v);
    write_gain(CfgBlueFromU, next.blue_from_u);
  endtask

  // Corners of the input space at the reset gains: clamping to zero and to
  // full scale on each channel, and neutral chroma that passes luma through.
  task automatic test_directed_extremes();
    pix_t corner[2];
    corner[0] = pix_t'(0);
    corner[1] = pix_t'(255);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corner[y]) begin
      foreach (corner[u]) begin
        foreach (corner[v]) begin
          send_word(corner[y], corner[u], ~corner[y], corner[v]);
        end
      end
    end
    send_word(8'd0, 8'd128, 8'd255, 8'd128);
    send_word(8'd1, 8'd127, 8'd254, 8'd129);
    send_word(8'd16, 8'd128, 8'd235, 8'd240);
    send_word(8'd235, 8'd16, 8'd16, 8'd16);
    send_word(8'hAA, 8'h55, 8'h55, 8'hAA);
    drain_results();
  endtask

  // Several gain settings, the extremes among them, then back to reset gains.
  task automatic test_gain_settings();
    coef_set_t setting;
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    apply_gains('0);
    send_random_words(50);
    apply_gains('{default: coef_t'(4095)});
    send_random_words(50);
    repeat (2) begin
      setting.red_from_v   = random_gain();
      setting.green_from_u = random_gain();
      setting.green_from_v = random_gain();
      setting.blue_from_u  = random_gain();
      apply_gains(setting);
      send_random_words(50);
    end
    apply_gains('{red_from_v: RstRedFromV, green_from_u: RstGreenFromU,
                  green_from_v: RstGreenFromV, blue_from_u: RstBlueFromU});
    send_random_words(50);
    drain_results();
  endtask

  // Random words under each idling pattern of the two handshakes.
  task automatic test_random_traffic();
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random_words(240);
    send_idle_pct = 54; recv_stall_pct = 0;
    send_random_words(240);
    send_idle_pct = 0;  recv_stall_pct = 54;
    send_random_words(240);
    send_idle_pct = 35; recv_stall_pct = 35;
    send_random_words(240);
    drain_results();
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // core fills up and must stall its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    recv_hold_cycles = 80;
    send_random_words(30);
    drain_results();
  endtask

  // Receiver side: random stalls, or a counted hold-off when one is asked.
  always @(negedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_channel(input string name, input pix_t want, input pix_t got);
    if (want !== got) begin
      mismatch_count++;
      error_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    bgr_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        error_count++;
        $display("%0t: result word with no prediction waiting", $realtime);
      end else begin
        want = pending_pairs.pop_front();
        check_channel("blue_first", want.blue_first, blue_first_o);
        check_channel("green_first", want.green_first, green_first_o);
        check_channel("red_first", want.red_first, red_first_o);
        check_channel("blue_second", want.blue_second, blue_second_o);
        check_channel("green_second", want.green_second, green_second_o);
        check_channel("red_second", want.red_second, red_second_o);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgRedFromV;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    luma_first_i  = '0;
    chroma_blue_i = '0;
    luma_second_i = '0;
    chroma_red_i  = '0;
    gains.red_from_v   = RstRedFromV;
    gains.green_from_u = RstGreenFromU;
    gains.green_from_v = RstGreenFromV;
    gains.blue_from_u  = RstBlueFromU;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_extremes();
    test_gain_settings();
    test_random_traffic();
    test_output_backpressure();

    if (pending_pairs.size() != 0) begin
      error_count++;
      $display("%0d predicted words never arrived", pending_pairs.size());
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
